>>> rtl/chtlp_pkg.sv
// Shared types and constants for the coordinate hash table with linear probing.
package chtlp_pkg;

    // Table geometry and key layout
    localparam int TableDepthDef = 1024;
    localparam int CoordW        = 32;
    localparam int KeyW          = 2 * CoordW;
    localparam int SlotOutW      = 10;
    localparam int StatusW       = 3;
    localparam int QueueDepth    = 4;

    // Hash multipliers (golden-ratio style constants)
    localparam logic [CoordW-1:0] MulX = 32'd2654435761;
    localparam logic [CoordW-1:0] MulZ = 32'd2246822519;

    // Command codes
    typedef enum logic {
        CMD_SAVE = 1'b0,
        CMD_LOAD = 1'b1
    } t_cmd;

    // Result status codes
    typedef enum logic [StatusW-1:0] {
        STAT_INSERTED = 3'd0,
        STAT_UPDATED  = 3'd1,
        STAT_HIT      = 3'd2,
        STAT_MISS     = 3'd3,
        STAT_FULL     = 3'd4
    } t_status;

    // Probe engine states
    typedef enum logic [1:0] {
        BS_CLEAR = 2'd0,
        BS_IDLE  = 2'd1,
        BS_PROBE = 2'd2
    } t_bstate;

endpackage

>>> rtl/coord_hash_table_linear_probe_core.sv
// Path: a request passes hash stages A, B and C (C adds reduction steps for a
//   non-power-of-two depth), the request queue, then a probe of 1 to TABLE_DEPTH slots.
// The probe engine walks one slot per cycle through the single read port of the key RAM
//   and takes the next queued request only once the current one has finished.
// Reset: i_rst_n synchronous, active low; a clearing pass then marks all TABLE_DEPTH slots
//   empty, one per cycle, with o_ready low while it runs.
module coord_hash_table_linear_probe_core #(
    parameter int TABLE_DEPTH = chtlp_pkg::TableDepthDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic signed [chtlp_pkg::CoordW-1:0] i_coord_x,
    input  logic signed [chtlp_pkg::CoordW-1:0] i_coord_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [chtlp_pkg::StatusW-1:0]       o_status,
    output logic [chtlp_pkg::SlotOutW-1:0]      o_slot_index
);

    import chtlp_pkg::*;

    localparam int EntryW = KeyW + $clog2(TABLE_DEPTH) + 1;

    logic              w_clear_busy, w_push, w_full, w_pop, w_empty;
    logic [EntryW-1:0] w_entry_in, w_entry_out;

    // hash front end
    chtlp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_z    (i_coord_z),
        .i_clear_busy (w_clear_busy),
        .o_push       (w_push),
        .o_entry      (w_entry_in),
        .i_queue_full (w_full)
    );

    // request queue
    chtlp_fifo #(
        .WIDTH (EntryW),
        .DEPTH (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_entry_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_entry_out),
        .o_empty (w_empty)
    );

    // probe engine
    chtlp_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .o_clear_busy  (w_clear_busy),
        .i_queue_empty (w_empty),
        .i_entry       (w_entry_out),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_slot_index  (o_slot_index)
    );

endmodule

>>> rtl/chtlp_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
module chtlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/chtlp_fifo.sv
// Small request queue between the hash front end and the probe engine.
module chtlp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = chtlp_pkg::QueueDepth
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PtrW-1:0]  r_wptr, r_rptr;
    logic [CntW-1:0]  r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_data[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PtrW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PtrW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> rtl/chtlp_front.sv
// Front end: accepts requests, computes the home slot and queues the request.
module chtlp_front #(
    parameter int TABLE_DEPTH = chtlp_pkg::TableDepthDef
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_cmd,
    input  logic signed [chtlp_pkg::CoordW-1:0]    i_coord_x,
    input  logic signed [chtlp_pkg::CoordW-1:0]    i_coord_z,
    input  logic                                   i_clear_busy,
    output logic                                   o_push,
    output logic [chtlp_pkg::KeyW+$clog2(TABLE_DEPTH):0] o_entry,
    input  logic                                   i_queue_full
);

    import chtlp_pkg::*;

    localparam int SlotW  = $clog2(TABLE_DEPTH);
    localparam bit IsPow2 = (TABLE_DEPTH == (1 << SlotW));
    localparam logic [CoordW-1:0] DepthQ = CoordW'(TABLE_DEPTH);
    // floor(2^32 / depth); the quotient estimate taken from it is low by at most one
    localparam logic [2*CoordW-1:0] RecipWide =
        ((2*CoordW)'(1) << CoordW) / (2*CoordW)'(TABLE_DEPTH);
    localparam logic [CoordW-1:0] Recip    = RecipWide[CoordW-1:0];
    localparam logic [1:0]        LastStep = 2'd2;

    // stage A: input register
    logic              r_a_valid, r_a_cmd;
    logic [CoordW-1:0] r_a_x, r_a_z;
    // stage B: products
    logic              r_b_valid, r_b_cmd;
    logic [CoordW-1:0] r_b_x, r_b_z, r_b_hx, r_b_hz;
    // stage C: slot reduction
    logic              r_c_valid, r_c_cmd, r_c_run;
    logic [CoordW-1:0] r_c_x, r_c_z, r_c_val, r_c_quo;
    logic [SlotW:0]    r_c_rem;
    logic [1:0]        r_c_cnt;

    logic                w_a_adv, w_a_free, w_b_adv, w_b_free, w_c_free, w_accept;
    logic [CoordW-1:0]   w_hx, w_hz, w_hash;
    logic [2*CoordW-1:0] w_prod;
    logic [CoordW-1:0]   w_diff, w_red;

    // handshake through the pipeline
    assign o_push   = r_c_valid && !r_c_run && !i_queue_full;
    assign w_c_free = !r_c_valid || o_push;
    assign w_b_adv  = r_b_valid && w_c_free;
    assign w_b_free = !r_b_valid || w_b_adv;
    assign w_a_adv  = r_a_valid && w_b_free;
    assign w_a_free = !r_a_valid || w_a_adv;
    assign o_ready  = w_a_free && !i_clear_busy;
    assign w_accept = i_valid && o_ready;

    // low halves of the two hash products
    assign w_hx   = r_a_x * MulX;
    assign w_hz   = r_a_z * MulZ;
    assign w_hash = r_b_hx ^ r_b_hz;

    // modulo by reciprocal: quotient estimate, remainder below twice the depth, one fixup
    assign w_prod = (2*CoordW)'(r_c_val) * (2*CoordW)'(Recip);
    assign w_diff = r_c_val - (r_c_quo * DepthQ);
    assign w_red  = (r_c_val >= DepthQ) ? (r_c_val - DepthQ) : r_c_val;

    assign o_entry = {r_c_cmd, r_c_x, r_c_z, r_c_rem[SlotW-1:0]};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_c_run   <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_adv) begin
                r_b_valid <= 1'b1;
            end else if (w_b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_b_adv) begin
                r_c_valid <= 1'b1;
                r_c_run   <= !IsPow2;
            end else begin
                if (o_push) begin
                    r_c_valid <= 1'b0;
                end
                if (r_c_run && (r_c_cnt == LastStep)) begin
                    r_c_run <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_cmd <= i_cmd;
            r_a_x   <= i_coord_x;
            r_a_z   <= i_coord_z;
        end
        if (w_a_adv) begin
            r_b_cmd <= r_a_cmd;
            r_b_x   <= r_a_x;
            r_b_z   <= r_a_z;
            r_b_hx  <= w_hx;
            r_b_hz  <= w_hz;
        end
        if (w_b_adv) begin
            r_c_cmd <= r_b_cmd;
            r_c_x   <= r_b_x;
            r_c_z   <= r_b_z;
            r_c_val <= w_hash;
            r_c_cnt <= '0;
            // power-of-two depth is a plain mask, otherwise three reduction steps follow
            r_c_rem <= IsPow2 ? {1'b0, w_hash[SlotW-1:0]} : '0;
        end else if (r_c_run) begin
            case (r_c_cnt)
                2'd0:    r_c_quo <= w_prod[2*CoordW-1:CoordW];
                2'd1:    r_c_val <= w_diff;
                default: r_c_rem <= w_red[SlotW:0];
            endcase
            r_c_cnt <= r_c_cnt + 1'b1;
        end
    end

endmodule

>>> rtl/chtlp_back.sv
// Probe engine: clears the table after reset, then walks slots for each queued request.
module chtlp_back #(
    parameter int TABLE_DEPTH = chtlp_pkg::TableDepthDef
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    output logic                                   o_clear_busy,
    input  logic                                   i_queue_empty,
    input  logic [chtlp_pkg::KeyW+$clog2(TABLE_DEPTH):0] i_entry,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [chtlp_pkg::StatusW-1:0]          o_status,
    output logic [chtlp_pkg::SlotOutW-1:0]         o_slot_index
);

    import chtlp_pkg::*;

    localparam int SlotW = $clog2(TABLE_DEPTH);
    localparam int RamW  = KeyW + 1;

    t_bstate          r_state, n_state;
    logic [SlotW-1:0] r_slot, n_slot;
    logic [SlotW-1:0] r_cnt, n_cnt;
    logic             r_cmd, n_cmd;
    logic [KeyW-1:0]  r_key, n_key;

    logic                r_out_valid;
    t_status             r_status, n_status;
    logic [SlotOutW-1:0] r_index, n_index;
    logic                w_finish;

    logic             w_we;
    logic [RamW-1:0]  w_wdata, w_rdata;
    logic             w_occ, w_match, w_out_free;

    // key store with occupied flag in the top bit
    chtlp_ram #(
        .WIDTH (RamW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (w_wdata),
        .i_raddr (n_slot),
        .o_rdata (w_rdata)
    );

    assign w_occ        = w_rdata[KeyW];
    assign w_match      = (w_rdata[KeyW-1:0] == r_key);
    assign w_out_free   = !r_out_valid || i_ready;
    assign o_clear_busy = (r_state == BS_CLEAR);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_index;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // request context
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_cmd <= n_cmd;
        r_key <= n_key;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_status <= n_status;
            r_index  <= n_index;
        end
    end

    // next state and probe decisions
    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_key    = r_key;
        n_status = STAT_MISS;
        n_index  = '0;
        w_finish = 1'b0;
        w_we     = 1'b0;
        w_wdata  = {1'b1, r_key};
        o_pop    = 1'b0;
        unique case (r_state)
            BS_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_slot == SlotW'(TABLE_DEPTH - 1)) begin
                    n_slot  = '0;
                    n_state = BS_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            BS_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_entry[KeyW+SlotW];
                    n_key   = i_entry[SlotW +: KeyW];
                    n_slot  = i_entry[SlotW-1:0];
                    n_cnt   = '0;
                    n_state = BS_PROBE;
                end
            end
            BS_PROBE: begin
                if (!w_occ) begin
                    // empty slot ends the probe
                    if (r_cmd == CMD_LOAD) begin
                        n_status = STAT_MISS;
                    end else begin
                        n_status = STAT_INSERTED;
                        n_index  = SlotOutW'(r_slot);
                    end
                    w_finish = w_out_free;
                    w_we     = w_out_free && (r_cmd == CMD_SAVE);
                end else if (w_match) begin
                    n_status = (r_cmd == CMD_LOAD) ? STAT_HIT : STAT_UPDATED;
                    n_index  = SlotOutW'(r_slot);
                    w_finish = w_out_free;
                end else if (r_cnt == SlotW'(TABLE_DEPTH - 1)) begin
                    // every slot visited
                    n_status = (r_cmd == CMD_LOAD) ? STAT_MISS : STAT_FULL;
                    w_finish = w_out_free;
                end else begin
                    n_slot = (r_slot == SlotW'(TABLE_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                if (w_finish) begin
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    // miss and full results carry slot zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == STAT_MISS || r_status == STAT_FULL) |-> r_index == '0)
        else $error("nonzero slot on miss or full");

    // no request can be queued while the table is being cleared
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == BS_CLEAR |-> i_queue_empty)
        else $error("request queued during clearing pass");

    // the table is written only by the clearing pass or an insert
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == BS_CLEAR) || (w_finish && n_status == STAT_INSERTED))
        else $error("unexpected table write");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the coordinate hash table with linear probing.
module tb;
    import chtlp_pkg::*;

    localparam int Depth      = TableDepthDef;
    localparam int HoldCycles = 400;
    localparam int WdogLimit  = 20000;
    localparam int RandItems  = 480;

    typedef struct packed {
        t_cmd              cmd;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic [SlotOutW-1:0] slot;
    } t_resp;

    logic                     i_clk     = 1'b0;
    logic                     i_rst_n   = 1'b0;
    logic                     i_valid   = 1'b0;
    logic                     i_cmd     = 1'b0;
    logic signed [CoordW-1:0] i_coord_x = '0;
    logic signed [CoordW-1:0] i_coord_z = '0;
    logic                     i_ready   = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [StatusW-1:0]       o_status;
    logic [SlotOutW-1:0]      o_slot_index;

    // Request queue for the driver, expected lookup results, keys known to be stored
    t_req              req_fifo[$];
    t_resp             expected_resp[$];
    logic [KeyW-1:0]   saved_keys[$];

    // Shadow copy of the table
    bit                slot_used[Depth];
    logic [KeyW-1:0]   slot_key[Depth];
    int                used_count = 0;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_asked      = 0;
    int hold_taken      = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int fail_cnt        = 0;
    int n_req           = 0;
    int n_resp          = 0;
    int stat_seen[5]    = '{default: 0};

    coord_hash_table_linear_probe_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_cmd        (i_cmd),
        .i_coord_x    (i_coord_x),
        .i_coord_z    (i_coord_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot_index (o_slot_index)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Home slot from the multiplicative hash of both coordinates
    function automatic int unsigned home_of(logic [CoordW-1:0] x, logic [CoordW-1:0] z);
        logic [CoordW-1:0] hx;
        logic [CoordW-1:0] hz;
        hx = x * MulX;
        hz = z * MulZ;
        return (hx ^ hz) % Depth;
    endfunction

    // Probe the shadow table; a save claims the first empty slot
    function automatic t_resp table_access(t_req r);
        t_resp           res;
        int unsigned     slot;
        logic [KeyW-1:0] key;
        bit              is_load;
        is_load = (r.cmd == CMD_LOAD);
        key = {r.x, r.z};
        slot = home_of(r.x, r.z);
        if (is_load) res.status = STAT_MISS;
        else res.status = STAT_FULL;
        res.slot = '0;
        for (int n = 0; n < Depth; n++) begin
            if (!slot_used[slot]) begin
                if (!is_load) begin
                    slot_used[slot] = 1'b1;
                    slot_key[slot]  = key;
                    used_count++;
                    res.status = STAT_INSERTED;
                    res.slot   = slot[SlotOutW-1:0];
                end
                break;
            end
            if (slot_key[slot] == key) begin
                if (is_load) res.status = STAT_HIT;
                else res.status = STAT_UPDATED;
                res.slot = slot[SlotOutW-1:0];
                break;
            end
            slot = (slot == Depth - 1) ? 0 : slot + 1;
        end
        return res;
    endfunction

    // Random key whose home slot is s (low z bits alone set the z term)
    function automatic logic [KeyW-1:0] key_homed_at(int unsigned s);
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] z;
        logic [CoordW-1:0] hx;
        logic [CoordW-1:0] hz;
        logic [CoordW-1:0] want;
        x = $urandom;
        hx = x * MulX;
        want = (hx ^ s) & (Depth - 1);
        z = $urandom & ~(Depth - 1);
        for (int zl = 0; zl < Depth; zl++) begin
            hz = zl * MulZ;
            if ((hz & (Depth - 1)) == want) begin
                z = z | zl;
                break;
            end
        end
        return {x, z};
    endfunction

    task automatic push_req(t_cmd c, logic [KeyW-1:0] k);
        t_req r;
        r.cmd = c;
        r.x   = k[KeyW-1:CoordW];
        r.z   = k[CoordW-1:0];
        req_fifo.push_back(r);
    endtask

    task automatic set_idle(int s_pct, int r_pct);
        sender_idle_pct = s_pct;
        recv_stall_pct  = r_pct;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk);
        while (req_fifo.size() != 0 || i_valid || expected_resp.size() != 0);
    endtask

    function automatic logic [KeyW-1:0] any_saved();
        return saved_keys[$urandom_range(saved_keys.size() - 1)];
    endfunction

    // Mix of fresh saves, colliding saves, updates, hits and misses
    task automatic random_batch(int count);
        int              r;
        logic [KeyW-1:0] k;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 35 || saved_keys.size() == 0) begin
                k = {$urandom, $urandom};
                push_req(CMD_SAVE, k);
                saved_keys.push_back(k);
            end else if (r < 45) begin
                // collide with a stored key, or pile up near the wrap point
                if ($urandom_range(1)) begin
                    k = any_saved();
                    k = key_homed_at(home_of(k[KeyW-1:CoordW], k[CoordW-1:0]));
                end else begin
                    k = key_homed_at($urandom_range(Depth - 1, Depth - 4));
                end
                push_req(CMD_SAVE, k);
                saved_keys.push_back(k);
            end else if (r < 60) begin
                push_req(CMD_SAVE, any_saved());
            end else if (r < 85) begin
                push_req(CMD_LOAD, any_saved());
            end else if (r < 93) begin
                push_req(CMD_LOAD, {$urandom, $urandom});
            end else begin
                k = any_saved();
                push_req(CMD_LOAD, key_homed_at(home_of(k[KeyW-1:CoordW], k[CoordW-1:0])));
            end
        end
    endtask

    // Driver: next transaction once the current one is taken
    always @(posedge i_clk) begin
        t_req cur;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (req_fifo.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                cur = req_fifo.pop_front();
                i_valid   <= 1'b1;
                i_cmd     <= cur.cmd;
                i_coord_x <= cur.x;
                i_coord_z <= cur.z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
        end else if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HoldCycles;
            i_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on request, check on result
    always @(posedge i_clk) begin
        t_req  req;
        t_resp want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                req.cmd = t_cmd'(i_cmd);
                req.x   = i_coord_x;
                req.z   = i_coord_z;
                expected_resp.push_back(table_access(req));
                n_req++;
            end
            if (o_valid && i_ready) begin
                n_resp++;
                if (o_status < 5) stat_seen[o_status]++;
                if (expected_resp.size() == 0) begin
                    $error("unexpected result: status %0d slot_index %0d", o_status, o_slot_index);
                    fail_cnt++;
                end else begin
                    want = expected_resp.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        fail_cnt++;
                    end
                    if (o_slot_index !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, o_slot_index);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WdogLimit) begin
            $display("timeout: no transaction for %0d cycles", WdogLimit);
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        logic [KeyW-1:0] kw1;
        logic [KeyW-1:0] kw2;
        logic [KeyW-1:0] kw3;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: miss, insert, update, hit, sign extremes, wrap-around probing
        set_idle(0, 0);
        kw1 = key_homed_at(Depth - 1);
        kw2 = key_homed_at(Depth - 1);
        kw3 = key_homed_at(Depth - 1);
        push_req(CMD_LOAD, {32'h0000_0000, 32'h0000_0000});
        push_req(CMD_SAVE, {32'h0000_0000, 32'h0000_0000});
        push_req(CMD_SAVE, {32'h0000_0000, 32'h0000_0000});
        push_req(CMD_LOAD, {32'h0000_0000, 32'h0000_0000});
        push_req(CMD_SAVE, {32'h8000_0000, 32'h7fff_ffff});
        push_req(CMD_SAVE, {32'h7fff_ffff, 32'h8000_0000});
        push_req(CMD_SAVE, {32'hffff_ffff, 32'hffff_ffff});
        push_req(CMD_SAVE, {32'hffff_ffff, 32'h0000_0001});
        push_req(CMD_SAVE, {32'h0000_0001, 32'hffff_ffff});
        push_req(CMD_LOAD, {32'h7fff_ffff, 32'h8000_0000});
        push_req(CMD_LOAD, {32'hffff_ffff, 32'h0000_0001});
        push_req(CMD_LOAD, {32'h7fff_ffff, 32'h7fff_ffff});
        push_req(CMD_LOAD, {32'h8000_0000, 32'h8000_0000});
        push_req(CMD_SAVE, kw1);
        push_req(CMD_SAVE, kw2);
        push_req(CMD_LOAD, kw3);
        push_req(CMD_LOAD, kw2);
        push_req(CMD_SAVE, kw2);
        push_req(CMD_LOAD, kw1);
        push_req(CMD_LOAD, {32'h0000_0000, 32'h0000_0000});
        saved_keys.push_back({32'h0000_0000, 32'h0000_0000});
        saved_keys.push_back({32'h8000_0000, 32'h7fff_ffff});
        saved_keys.push_back({32'hffff_ffff, 32'hffff_ffff});
        saved_keys.push_back(kw1);
        saved_keys.push_back(kw2);
        wait_drain();

        // Random traffic; the first phase also backs up the block with a hold-off
        set_idle(0, 0);
        random_batch(RandItems / 4);
        hold_asked++;
        wait_drain();
        set_idle(88, 0);
        random_batch(RandItems / 4);
        wait_drain();
        set_idle(0, 88);
        random_batch(RandItems / 4);
        wait_drain();
        set_idle(32, 32);
        random_batch(RandItems / 4);
        wait_drain();

        repeat (40) @(posedge i_clk);
        $display("covered %0d requests, %0d results: %0d inserted, %0d updated, %0d hits,",
                 n_req, n_resp, stat_seen[STAT_INSERTED], stat_seen[STAT_UPDATED],
                 stat_seen[STAT_HIT]);
        $display("  %0d misses, %0d full; table reached %0d of %0d slots under four idle mixes",
                 stat_seen[STAT_MISS], stat_seen[STAT_FULL], used_count, Depth);
        if (fail_cnt == 0 && expected_resp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/chtlp_pkg.sv
rtl/chtlp_ram.sv
rtl/chtlp_fifo.sv
rtl/chtlp_front.sv
rtl/chtlp_back.sv
rtl/coord_hash_table_linear_probe_core.sv
verif/tb.sv
